FILE: sv/fssr_pkg.sv
// Shared types, constants and fp32 compare helpers for the float sum/scale/clamp block.
// No dependencies.
`default_nettype none
package fssr_pkg;

	localparam int LANES  = 8;
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] RST_SCALE = 32'h3F80_0000;
	localparam logic [31:0] RST_LOW   = 32'hFF80_0000;
	localparam logic [31:0] RST_HIGH  = 32'h7F80_0000;

	typedef enum logic [1:0] {
		CFG_SCALE    = 2'd0,
		CFG_CLAMP_LO = 2'd1,
		CFG_CLAMP_HI = 2'd2
	} cfg_idx_t;

	typedef enum logic {FP_ADD, FP_MUL} fp_op_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_ACC, BK_RED, BK_MUL, BK_CLAMP, BK_FIN, BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [31:0]       sample;
		logic              last;
		logic [31:0]       prior;
		logic [LANE_W-1:0] lane;
	} work_t;

	typedef struct packed {
		logic   valid;
		fp_op_t op;
	} fpu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fpu_stat_t;

	typedef struct packed {
		logic take;
		logic load;
	} back_stat_t;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	// monotonic key: unsigned order of keys equals numeric order
	function automatic logic [31:0] ord_key(input logic [31:0] x);
		return x[31] ? ~x : (x | 32'h8000_0000);
	endfunction

	function automatic logic [31:0] fmax_num(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (is_nan(a) && is_nan(b))
			r = CANON_NAN;
		else if (is_nan(a))
			r = b;
		else if (is_nan(b))
			r = a;
		else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			r = (a[31] & b[31]) ? a : 32'd0;
		else
			r = (ord_key(a) >= ord_key(b)) ? a : b;
		return r;
	endfunction

	function automatic logic [31:0] fmin_num(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		if (is_nan(a) && is_nan(b))
			r = CANON_NAN;
		else if (is_nan(a))
			r = b;
		else if (is_nan(b))
			r = a;
		else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			r = (a[31] | b[31]) ? 32'h8000_0000 : 32'd0;
		else
			r = (ord_key(a) <= ord_key(b)) ? a : b;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/fssr_fpu.sv
// Three-stage fp32 add/multiply unit: operate, normalize, round (nearest even).
// Depends on fssr_pkg.
`default_nettype none
module fssr_fpu (
	input  wire                  clk,
	input  wire                  arst_n,
	input  fssr_pkg::fpu_req_t   req,
	input  wire  [31:0]          a,
	input  wire  [31:0]          b,
	output fssr_pkg::fpu_stat_t  stat,
	output logic [31:0]          result
);
	import fssr_pkg::*;

	function automatic logic [5:0] lzc47(input logic [46:0] p);
		logic [5:0] n;
		n = 6'd47;
		for (int i = 0; i < 47; i++) begin
			if (p[i])
				n = 6'(46 - i);
		end
		return n;
	endfunction

	logic v_s1, v_s2, v_s3;
	logic spec_s1, spec_s2;
	logic [31:0] sval_s1, sval_s2;
	logic sign_s1, sign_s2;
	logic signed [10:0] exp_s1, exp_s2;
	logic [47:0] man_s1, man_s2;
	logic stk_s2;
	logic [31:0] res_s3;

	// stage 1
	logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic swap;
	logic [31:0] xb, xs;
	logic [7:0] eb, es, dd, ea, ebm;
	logic [4:0] dcap;
	logic [26:0] mbx, msx, sh;
	logic [27:0] sum28;
	logic [47:0] prod;
	logic spec_n, sign_n;
	logic [31:0] sval_n;
	logic signed [10:0] exp_n;
	logic [47:0] man_n;

	always_comb begin
		nan_a  = is_nan(a);
		nan_b  = is_nan(b);
		inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		zero_a = (a[30:0] == 31'd0);
		zero_b = (b[30:0] == 31'd0);
		swap   = b[30:0] > a[30:0];
		xb     = swap ? b : a;
		xs     = swap ? a : b;
		eb     = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
		es     = (xs[30:23] == 8'd0) ? 8'd1 : xs[30:23];
		dd     = eb - es;
		dcap   = (dd > 8'd27) ? 5'd27 : dd[4:0];
		mbx    = {(xb[30:23] != 8'd0), xb[22:0], 3'b000};
		msx    = {(xs[30:23] != 8'd0), xs[22:0], 3'b000};
		sh     = msx >> dcap;
		sh[0]  = sh[0] | (|(msx & ~({27{1'b1}} << dcap)));
		sum28  = (xb[31] == xs[31]) ? ({1'b0, mbx} + {1'b0, sh}) : ({1'b0, mbx} - {1'b0, sh});
		ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		ebm    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		prod   = 48'({(a[30:23] != 8'd0), a[22:0]}) * 48'({(b[30:23] != 8'd0), b[22:0]});

		spec_n = 1'b0;
		sval_n = CANON_NAN;
		sign_n = 1'b0;
		exp_n  = 11'sd0;
		man_n  = 48'd0;
		case (req.op)
			FP_ADD: begin
				sign_n = xb[31];
				exp_n  = $signed({3'b000, eb});
				man_n  = {sum28, 20'd0};
				if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
					spec_n = 1'b1;
				end else if (inf_a) begin
					spec_n = 1'b1;
					sval_n = a;
				end else if (inf_b) begin
					spec_n = 1'b1;
					sval_n = b;
				end else if (sum28 == 28'd0) begin
					spec_n = 1'b1;
					sval_n = {a[31] & b[31], 31'd0};
				end
			end
			FP_MUL: begin
				sign_n = a[31] ^ b[31];
				exp_n  = $signed({3'b000, ea}) + $signed({3'b000, ebm}) - 11'sd127;
				man_n  = prod;
				if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
					spec_n = 1'b1;
				end else if (inf_a || inf_b) begin
					spec_n = 1'b1;
					sval_n = {a[31] ^ b[31], 31'h7F80_0000};
				end else if (zero_a || zero_b) begin
					spec_n = 1'b1;
					sval_n = {a[31] ^ b[31], 31'd0};
				end
			end
			default: spec_n = 1'b1;
		endcase
	end

	// stage 2: normalize so the hidden bit sits at 46
	logic [47:0] p2;
	logic signed [10:0] e2;
	logic stk2;
	logic [5:0] lz;
	logic signed [10:0] rsh;
	logic [5:0] rcap;

	always_comb begin
		p2   = man_s1;
		e2   = exp_s1;
		stk2 = 1'b0;
		if (p2[47]) begin
			stk2 = p2[0];
			p2   = p2 >> 1;
			e2   = e2 + 11'sd1;
		end
		lz   = lzc47(p2[46:0]);
		rsh  = 11'sd1 - e2;
		rcap = (rsh > 11'sd63) ? 6'd63 : rsh[5:0];
		if ((e2 - $signed({5'd0, lz})) >= 11'sd1) begin
			p2 = p2 << lz;
			e2 = e2 - $signed({5'd0, lz});
		end else if (e2 >= 11'sd1) begin
			p2 = p2 << 6'(e2 - 11'sd1);
			e2 = 11'sd1;
		end else begin
			stk2 = stk2 | (|(p2 & ~({48{1'b1}} << rcap)));
			p2   = p2 >> rcap;
			e2   = 11'sd1;
		end
	end

	// stage 3: round and pack
	logic up;
	logic [24:0] m25;
	logic signed [10:0] e3;
	logic [31:0] packed_n;

	always_comb begin
		up  = man_s2[22] & ((|man_s2[21:0]) | stk_s2 | man_s2[23]);
		m25 = {1'b0, man_s2[46:23]} + {24'd0, up};
		e3  = m25[24] ? (exp_s2 + 11'sd1) : exp_s2;
		if (e3 >= 11'sd255)
			packed_n = {sign_s2, 31'h7F80_0000};
		else if (m25[24])
			packed_n = {sign_s2, e3[7:0], 23'd0};
		else
			packed_n = {sign_s2, m25[23] ? e3[7:0] : 8'd0, m25[22:0]};
		if (spec_s2)
			packed_n = sval_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		spec_s1 <= spec_n;
		sval_s1 <= sval_n;
		sign_s1 <= sign_n;
		exp_s1  <= exp_n;
		man_s1  <= man_n;
		spec_s2 <= spec_s1;
		sval_s2 <= sval_s1;
		sign_s2 <= sign_s1;
		exp_s2  <= e2;
		man_s2  <= p2;
		stk_s2  <= stk2;
		res_s3  <= packed_n;
	end

	assign stat.busy = v_s1 | v_s2;
	assign stat.done = v_s3;
	assign result    = res_s3;

endmodule
`default_nettype wire

FILE: sv/fssr_front.sv
// Input side: accepts items, tags each with its partial lane, queues them.
// Depends on fssr_pkg.
`default_nettype none
module fssr_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  wire  [31:0]        sample,
	input  wire                last_item,
	input  wire  [31:0]        prior_total,
	output logic               avail,
	output fssr_pkg::work_t    work,
	input  wire                take
);
	import fssr_pkg::*;

	work_t             q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic [LANE_W-1:0] lane_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign avail   = (cnt_q != '0);
	assign do_push = push & ~full;
	assign do_pop  = take & avail;
	assign work    = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			q_mem[wr_ptr_q] <= '{sample: sample, last: last_item, prior: prior_total, lane: lane_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			lane_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (last_item || lane_q == LANE_W'(LANES - 1))
					lane_q <= '0;
				else
					lane_q <= lane_q + 1'b1;
			end
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: sv/fssr_back.sv
// Execution side: partial sums, final reduce, scale, clamp, add, result register.
// Depends on fssr_pkg; drives the shared fssr_fpu.
`default_nettype none
module fssr_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   avail,
	input  fssr_pkg::work_t       work,
	output fssr_pkg::back_stat_t  stat,
	input  wire  [31:0]           scale_factor,
	input  wire  [31:0]           clamp_low,
	input  wire  [31:0]           clamp_high,
	output fssr_pkg::fpu_req_t    fpu_req,
	output logic [31:0]           fpu_a,
	output logic [31:0]           fpu_b,
	input  fssr_pkg::fpu_stat_t   fpu_stat,
	input  wire  [31:0]           fpu_result,
	input  wire                   pop,
	output logic                  out_valid,
	output logic [31:0]           total
);
	import fssr_pkg::*;

	back_state_t       st_q, st_d;
	work_t             cur_q;
	logic [31:0]       partial_q [LANES];
	logic [LANE_W-1:0] idx_q;
	logic [31:0]       acc_q;
	logic              issued_q;
	logic              out_valid_q;
	logic [31:0]       total_q;
	logic              need_op, fin;

	always_comb begin
		st_d          = st_q;
		stat.take     = 1'b0;
		stat.load     = 1'b0;
		need_op       = 1'b0;
		fpu_req.op    = FP_ADD;
		fpu_a         = acc_q;
		fpu_b         = partial_q[idx_q];
		fin           = issued_q & fpu_stat.done;
		case (st_q)
			BK_IDLE: begin
				if (avail) begin
					stat.take = 1'b1;
					st_d      = BK_ACC;
				end
			end
			BK_ACC: begin
				need_op = 1'b1;
				fpu_a   = partial_q[cur_q.lane];
				fpu_b   = cur_q.sample;
				if (fin)
					st_d = cur_q.last ? BK_RED : BK_IDLE;
			end
			BK_RED: begin
				need_op = 1'b1;
				if (fin && idx_q == LANE_W'(LANES - 1))
					st_d = BK_MUL;
			end
			BK_MUL: begin
				need_op    = 1'b1;
				fpu_req.op = FP_MUL;
				fpu_b      = scale_factor;
				if (fin)
					st_d = BK_CLAMP;
			end
			BK_CLAMP: st_d = BK_FIN;
			BK_FIN: begin
				need_op = 1'b1;
				fpu_b   = cur_q.prior;
				if (fin)
					st_d = BK_OUT;
			end
			BK_OUT: begin
				if (!out_valid_q) begin
					stat.load = 1'b1;
					st_d      = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
		fpu_req.valid = need_op & ~issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			for (int i = 0; i < LANES; i++)
				partial_q[i] <= 32'd0;
		end else begin
			st_q <= st_d;
			if (fpu_req.valid)
				issued_q <= 1'b1;
			else if (fin)
				issued_q <= 1'b0;
			if (stat.load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (st_q == BK_ACC && fin) begin
				partial_q[cur_q.lane] <= fpu_result;
				idx_q <= '0;
			end
			if (st_q == BK_RED && fin)
				idx_q <= idx_q + 1'b1;
			if (stat.load) begin
				for (int i = 0; i < LANES; i++)
					partial_q[i] <= 32'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.take)
			cur_q <= work;
		if (st_q == BK_ACC && fin)
			acc_q <= 32'd0;
		else if (fin)
			acc_q <= fpu_result;
		else if (st_q == BK_CLAMP)
			acc_q <= fmin_num(fmax_num(acc_q, clamp_low), clamp_high);
		if (stat.load)
			total_q <= acc_q;
	end

	assign out_valid = out_valid_q;
	assign total     = total_q;

endmodule
`default_nettype wire

FILE: sv/float_sum_scale_clamp_reduce.sv
// Top level of the fp32 batch sum with scale, clamp and accumulate.
// Depends on fssr_pkg, fssr_front, fssr_back, fssr_fpu.
//
// Input channel: push/full. Each item carries one fp32 sample, a last flag
// and the prior output value (used only on the last item). A 4-entry queue
// takes items while the back end works. Result channel: empty/pop; one total
// appears per batch, after its last item, and waits in an output register
// until popped. A stalled receiver stops the back end only once a second
// total is ready; the input queue keeps filling until full.
// Samples go round-robin into 8 partial sums; the final sum adds them in lane
// order, multiplies by scale_factor, clamps to [clamp_low, clamp_high] and
// adds prior_total. All arithmetic runs through one shared 3-stage fp unit,
// one operation at a time.
// Config: cfg_we/cfg_index/cfg_data, to be written only while idle; the block does not enforce this.
// Reset (arst_n low): registers take 1.0, -inf, +inf; partials clear to +0.
`default_nettype none
module float_sum_scale_clamp_reduce (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [31:0] sample,
	input  wire         last_item,
	input  wire  [31:0] prior_total,
	output logic        empty,
	input  wire         pop,
	output logic [31:0] total,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import fssr_pkg::*;

	logic [31:0] scale_q, low_q, high_q;
	logic        avail;
	work_t       work;
	back_stat_t  back_stat;
	fpu_req_t    fpu_req;
	fpu_stat_t   fpu_stat;
	logic [31:0] fpu_a, fpu_b, fpu_result;
	logic        out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= RST_SCALE;
			low_q   <= RST_LOW;
			high_q  <= RST_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE:    scale_q <= cfg_data;
				CFG_CLAMP_LO: low_q   <= cfg_data;
				CFG_CLAMP_HI: high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	fssr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.last_item  (last_item),
		.prior_total(prior_total),
		.avail      (avail),
		.work       (work),
		.take       (back_stat.take)
	);

	fssr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.work        (work),
		.stat        (back_stat),
		.scale_factor(scale_q),
		.clamp_low   (low_q),
		.clamp_high  (high_q),
		.fpu_req     (fpu_req),
		.fpu_a       (fpu_a),
		.fpu_b       (fpu_b),
		.fpu_stat    (fpu_stat),
		.fpu_result  (fpu_result),
		.pop         (pop),
		.out_valid   (out_valid),
		.total       (total)
	);

	fssr_fpu u_fpu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (fpu_req),
		.a     (fpu_a),
		.b     (fpu_b),
		.stat  (fpu_stat),
		.result(fpu_result)
	);

	assign empty = ~out_valid;

	a_fpu_single: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_req.valid |-> !fpu_stat.busy && !fpu_stat.done)
		else $error("fp unit issued while an operation is in flight");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.load |-> empty)
		else $error("result register overwritten");

	a_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_stat.done |=> !fpu_stat.busy)
		else $error("fp unit still busy after completion");

endmodule
`default_nettype wire
